// ----- src/tod_pkg.sv -----
// Package for the BCD time-of-day clock: field widths, register indexes and digit helpers.
package tod_pkg;

    localparam int TENTHS_W  = 4;
    localparam int SECONDS_W = 7;
    localparam int MINUTES_W = 7;
    localparam int HOURS_W   = 8;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_TENTHS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_SECONDS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_MINUTES = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_HOURS   = 2'd3;

    // Input item kinds (tuser)
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Digit limits: a digit at or above its limit wraps on increment
    localparam logic [3:0] ONES_LAST       = 4'd9;
    localparam logic [2:0] SIXTY_TENS_LAST = 3'd5;

    typedef struct packed {
        logic                 carry;
        logic [SECONDS_W-1:0] value;
    } t_sixty;

    // Advance a 00-59 BCD pair; out-of-range tens digits wrap only on a ones carry
    function automatic t_sixty advance_sixty(input logic [SECONDS_W-1:0] v);
        t_sixty     r;
        logic [3:0] ones;
        logic [2:0] tens;
        ones    = v[3:0];
        tens    = v[6:4];
        r.carry = 1'b0;
        if (ones >= ONES_LAST) begin
            ones = 4'd0;
            if (tens >= SIXTY_TENS_LAST) begin
                tens    = 3'd0;
                r.carry = 1'b1;
            end else begin
                tens = tens + 3'd1;
            end
        end else begin
            ones = ones + 4'd1;
        end
        r.value = {tens, ones};
        return r;
    endfunction

    // Advance the hours: tens digit is bit 4 only, 11 wraps to 00 with PM toggled
    function automatic logic [HOURS_W-1:0] advance_hours(input logic [HOURS_W-1:0] h);
        logic [3:0] ones;
        logic       tens;
        logic       pm;
        ones = h[3:0];
        tens = h[4];
        pm   = h[7];
        if ((!tens && (ones >= ONES_LAST)) || (tens && (ones >= 4'd1))) begin
            ones = 4'd0;
            if (tens) begin
                tens = 1'b0;
                pm   = ~pm;
            end else begin
                tens = 1'b1;
            end
        end else begin
            ones = ones + 4'd1;
        end
        return {pm, 2'b00, tens, ones};
    endfunction

endpackage

// ----- src/bcd_time_of_day_clock_alarm.sv -----
// Top level of the BCD time-of-day clock with alarm compare.

// BCD time-of-day clock. Each input item is either a tick (tuser = 0), which
// advances the tenths digit by one while the running bit is set, with the carry
// rippling through seconds, minutes and 12-hour hours (PM in bit 7), or a load
// (tuser = 1), which sets all four time registers as given. Every item yields
// one result item carrying the time after it and an alarm flag that is set when
// a running tick leaves the time equal to the four alarm registers. The block
// takes one item per clock cycle while the output is not stalled; each item passes
// through the input register, then the result register, and a stalled output holds
// at most one item in each of the two registers. The user must write the alarm registers
// through the configuration port while the block is idle; the block does not enforce it.
module bcd_time_of_day_clock_alarm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [tod_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [tod_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: running[0], set_tenths[4:1], set_seconds[11:5],
    //        set_minutes[18:12], set_hours[26:19], zero fill [31:27]
    input  logic [tod_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // tuser: cmd[0]
    input  logic                             i_s_tuser,
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: now_tenths[3:0], now_seconds[10:4], now_minutes[17:11],
    //        now_hours[25:18], zero fill [31:26]
    output logic [tod_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // tuser: alarm_hit[0]
    output logic                             o_m_tuser
);
    import tod_pkg::*;

    // alarm registers
    logic [TENTHS_W-1:0]  r_alarm_tenths;
    logic [SECONDS_W-1:0] r_alarm_seconds;
    logic [MINUTES_W-1:0] r_alarm_minutes;
    logic [HOURS_W-1:0]   r_alarm_hours;

    // time registers
    logic [TENTHS_W-1:0]  r_tenths,  n_tenths;
    logic [SECONDS_W-1:0] r_seconds, n_seconds;
    logic [MINUTES_W-1:0] r_minutes, n_minutes;
    logic [HOURS_W-1:0]   r_hours,   n_hours;
    logic                 n_hit;

    // input register
    logic                 r_in_valid;
    logic                 r_in_cmd;
    logic                 r_in_running;
    logic [TENTHS_W-1:0]  r_in_tenths;
    logic [SECONDS_W-1:0] r_in_seconds;
    logic [MINUTES_W-1:0] r_in_minutes;
    logic [HOURS_W-1:0]   r_in_hours;

    // result register
    logic                 r_out_valid;
    logic [TENTHS_W-1:0]  r_out_tenths;
    logic [SECONDS_W-1:0] r_out_seconds;
    logic [MINUTES_W-1:0] r_out_minutes;
    logic [HOURS_W-1:0]   r_out_hours;
    logic                 r_out_hit;

    logic   advance;
    logic   s_accept;
    t_sixty sec_step;
    t_sixty min_step;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_tenths  <= '0;
            r_alarm_seconds <= '0;
            r_alarm_minutes <= '0;
            r_alarm_hours   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ALARM_TENTHS:  r_alarm_tenths  <= i_cfg_data[TENTHS_W-1:0];
                CFG_ALARM_SECONDS: r_alarm_seconds <= i_cfg_data[SECONDS_W-1:0];
                CFG_ALARM_MINUTES: r_alarm_minutes <= i_cfg_data[MINUTES_W-1:0];
                CFG_ALARM_HOURS:   r_alarm_hours   <= i_cfg_data[HOURS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_cmd     <= i_s_tuser;
            r_in_running <= i_s_tdata[0];
            r_in_tenths  <= i_s_tdata[4:1];
            r_in_seconds <= i_s_tdata[11:5];
            r_in_minutes <= i_s_tdata[18:12];
            r_in_hours   <= i_s_tdata[26:19];
        end
    end

    always_comb begin
        sec_step  = advance_sixty(r_seconds);
        min_step  = advance_sixty(r_minutes);
        n_tenths  = r_tenths;
        n_seconds = r_seconds;
        n_minutes = r_minutes;
        n_hours   = r_hours;
        n_hit     = 1'b0;
        if (r_in_cmd == CMD_LOAD) begin
            n_tenths  = r_in_tenths;
            n_seconds = r_in_seconds;
            n_minutes = r_in_minutes;
            n_hours   = r_in_hours;
        end else if (r_in_running) begin
            if (r_tenths >= ONES_LAST) begin
                n_tenths  = '0;
                n_seconds = sec_step.value;
                if (sec_step.carry) begin
                    n_minutes = min_step.value;
                    if (min_step.carry) begin
                        n_hours = advance_hours(r_hours);
                    end
                end
            end else begin
                n_tenths = r_tenths + 4'd1;
            end
            n_hit = (n_tenths == r_alarm_tenths) && (n_seconds == r_alarm_seconds) &&
                    (n_minutes == r_alarm_minutes) && (n_hours == r_alarm_hours);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenths  <= '0;
            r_seconds <= '0;
            r_minutes <= '0;
            r_hours   <= '0;
        end else if (advance) begin
            r_tenths  <= n_tenths;
            r_seconds <= n_seconds;
            r_minutes <= n_minutes;
            r_hours   <= n_hours;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tenths  <= n_tenths;
            r_out_seconds <= n_seconds;
            r_out_minutes <= n_minutes;
            r_out_hours   <= n_hours;
            r_out_hit     <= n_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_hours, r_out_minutes, r_out_seconds, r_out_tenths};
    assign o_m_tuser  = r_out_hit;

    // a flagged result carries exactly the alarm time
    a_hit_matches_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |->
            (r_out_tenths == r_alarm_tenths) && (r_out_seconds == r_alarm_seconds) &&
            (r_out_minutes == r_alarm_minutes) && (r_out_hours == r_alarm_hours))
        else $error("alarm flag set on a time that differs from the alarm");

    // a load puts its fields straight into the time registers
    a_load_sets_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_cmd == CMD_LOAD)) |=>
            (r_tenths == $past(r_in_tenths)) && (r_seconds == $past(r_in_seconds)) &&
            (r_minutes == $past(r_in_minutes)) && (r_hours == $past(r_in_hours)))
        else $error("load item did not set the time");

    // a tick while stopped leaves the time alone and raises no alarm
    a_stopped_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_cmd == CMD_TICK) && !r_in_running) |=>
            ($stable(r_tenths) && $stable(r_seconds) && $stable(r_minutes) &&
             $stable(r_hours) && !r_out_hit))
        else $error("stopped tick changed the time or flagged an alarm");

    // the time only moves when an item goes through
    a_time_moves_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_tenths) && $stable(r_seconds) &&
                      $stable(r_minutes) && $stable(r_hours)))
        else $error("time changed without an item");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the BCD time-of-day clock with alarm compare.
`timescale 1ns / 100ps

module tb;
    import tod_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 600;

    typedef struct packed {
        logic [TENTHS_W-1:0]  tenths;
        logic [SECONDS_W-1:0] seconds;
        logic [MINUTES_W-1:0] minutes;
        logic [HOURS_W-1:0]   hours;
    } t_tod_time;

    typedef struct packed {
        logic      cmd;
        logic      running;
        t_tod_time set;
    } t_tod_item;

    typedef struct packed {
        t_tod_time now;
        logic      hit;
    } t_tod_result;

    typedef struct packed {
        t_tod_item   item;
        logic        typed;
        t_tod_result want;
    } t_clock_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tuser;

    bcd_time_of_day_clock_alarm dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // predictor state
    t_tod_time   clock_now;
    t_tod_time   alarm_time;
    t_tod_result pending_times[$];
    t_clock_row  directed_rows[$];

    int  cycles;
    int  items_sent;
    int  loads_sent;
    int  results_seen;
    int  alarm_hits;
    int  mism_count;
    int  phases_run;
    bit  calm;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    // 00-59 pair; out-of-range tens digits only wrap once a ones carry reaches them
    function automatic logic [6:0] bump_sixty(input logic [6:0] v, output logic carry);
        int o;
        int t;
        o     = int'(v[3:0]) + 1;
        t     = int'(v[6:4]);
        carry = 1'b0;
        if (o > 9) begin
            o = 0;
            t = t + 1;
            if (t > 5) begin
                t     = 0;
                carry = 1'b1;
            end
        end
        return {t[2:0], o[3:0]};
    endfunction

    function automatic logic [7:0] bump_hours(input logic [7:0] h);
        int   o;
        logic tn;
        logic pm;
        o  = int'(h[3:0]) + 1;
        tn = h[4];
        pm = h[7];
        if (tn ? (o > 1) : (o > 9)) begin
            o = 0;
            if (tn) begin
                tn = 1'b0;
                pm = ~pm;
            end else begin
                tn = 1'b1;
            end
        end
        return {pm, 2'b00, tn, o[3:0]};
    endfunction

    function automatic t_tod_time tick_time(input t_tod_time t);
        t_tod_time n;
        logic      c;
        n = t;
        if (t.tenths >= 4'd9) begin
            n.tenths  = '0;
            n.seconds = bump_sixty(t.seconds, c);
            if (c) begin
                n.minutes = bump_sixty(t.minutes, c);
                if (c) n.hours = bump_hours(t.hours);
            end
        end else begin
            n.tenths = t.tenths + 4'd1;
        end
        return n;
    endfunction

    function automatic t_tod_time step_time(input t_tod_item it, input t_tod_time t);
        if (it.cmd == CMD_LOAD) return it.set;
        if (it.running) return tick_time(t);
        return t;
    endfunction

    function automatic t_tod_result tod_advance(input t_tod_item it);
        t_tod_result r;
        clock_now = step_time(it, clock_now);
        r.now = clock_now;
        r.hit = (it.cmd == CMD_TICK) && it.running && (clock_now == alarm_time);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_tod_time mk_time(input logic [3:0] t, input logic [6:0] s,
                                          input logic [6:0] m, input logic [7:0] h);
        t_tod_time v;
        v.tenths  = t;
        v.seconds = s;
        v.minutes = m;
        v.hours   = h;
        return v;
    endfunction

    function automatic t_tod_item load_item(input t_tod_time v, input logic run);
        t_tod_item it;
        it.cmd     = CMD_LOAD;
        it.running = run;
        it.set     = v;
        return it;
    endfunction

    // set fields of a tick carry junk; the block must ignore them
    function automatic t_tod_item tick_item(input logic run);
        t_tod_item it;
        it.cmd     = CMD_TICK;
        it.running = run;
        it.set     = t_tod_time'($urandom);
        return it;
    endfunction

    function automatic t_tod_result mk_result(input t_tod_time v, input logic hit);
        t_tod_result r;
        r.now = v;
        r.hit = hit;
        return r;
    endfunction

    function automatic t_tod_time valid_time();
        t_tod_time v;
        logic      tn;
        tn = 1'($urandom);
        v.tenths  = 4'($urandom_range(9));
        v.seconds = {3'($urandom_range(5)), 4'($urandom_range(9))};
        v.minutes = {3'($urandom_range(5)), 4'($urandom_range(9))};
        v.hours   = {1'($urandom), 2'b00, tn, 4'($urandom_range(tn ? 1 : 9))};
        return v;
    endfunction

    function automatic t_tod_time rand_time();
        t_tod_time v;
        v = valid_time();
        case ($urandom_range(5))
            0: v = t_tod_time'($urandom);
            1, 2: begin
                // close to a carry into the minutes or hours
                v.tenths  = 4'd9 - 4'($urandom_range(3));
                v.seconds = 7'h59;
                if ($urandom_range(1)) v.minutes = 7'h59;
            end
            3: begin
                // out-of-range digits
                v.seconds = {3'($urandom_range(5, 7)), 4'($urandom_range(8, 15))};
                v.minutes = 7'($urandom);
                v.hours   = {1'($urandom), 2'($urandom), 1'($urandom),
                             4'($urandom_range(8, 15))};
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_row(input t_tod_item it, input logic typed, input t_tod_result want);
        t_clock_row r;
        r.item  = it;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ALARM_TENTHS:  alarm_time.tenths  = data[TENTHS_W-1:0];
            CFG_ALARM_SECONDS: alarm_time.seconds = data[SECONDS_W-1:0];
            CFG_ALARM_MINUTES: alarm_time.minutes = data[MINUTES_W-1:0];
            default:           alarm_time.hours   = data[HOURS_W-1:0];
        endcase
    endtask

    // upper bits of the narrow registers get junk now and then
    task automatic set_alarm(input t_tod_time a, input logic junk);
        logic [7:0] j;
        j = junk ? 8'($urandom) : 8'h00;
        write_reg(CFG_ALARM_TENTHS,  {j[7:4], a.tenths});
        write_reg(CFG_ALARM_SECONDS, {j[7], a.seconds});
        write_reg(CFG_ALARM_MINUTES, {j[6], a.minutes});
        write_reg(CFG_ALARM_HOURS,   a.hours);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input t_tod_item it, input logic typed, input t_tod_result want);
        t_tod_result r;
        while (!calm && $urandom_range(99) < 24) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.cmd;
        i_s_tdata  <= {5'b0, it.set.hours, it.set.minutes, it.set.seconds,
                       it.set.tenths, it.running};
        do @(posedge i_clk); while (!o_s_tready);
        r = tod_advance(it);
        pending_times.push_back(typed ? want : r);
        items_sent++;
        if (it.cmd == CMD_LOAD) loads_sent++;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_times.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- result checker

    always @(posedge i_clk) begin
        t_tod_result want;
        t_tod_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.now.tenths  = o_m_tdata[3:0];
            got.now.seconds = o_m_tdata[10:4];
            got.now.minutes = o_m_tdata[17:11];
            got.now.hours   = o_m_tdata[25:18];
            got.hit         = o_m_tuser;
            results_seen++;
            if (got.hit) alarm_hits++;
            if (pending_times.size() == 0) begin
                mism_count++;
                if (mism_count <= 10)
                    $display("[%0t] unexpected result t=%h s=%h m=%h h=%h hit=%b", $time,
                             got.now.tenths, got.now.seconds, got.now.minutes,
                             got.now.hours, got.hit);
            end else begin
                want = pending_times.pop_front();
                if (got.now.tenths != want.now.tenths || got.now.seconds != want.now.seconds ||
                    got.now.minutes != want.now.minutes || got.now.hours != want.now.hours ||
                    got.hit != want.hit) begin
                    mism_count++;
                    if (mism_count <= 10) begin
                        $write("[%0t] mismatch: exp t=%h s=%h m=%h h=%h hit=%b, ",
                               $time, want.now.tenths, want.now.seconds, want.now.minutes,
                               want.now.hours, want.hit);
                        $display("got t=%h s=%h m=%h h=%h hit=%b", got.now.tenths,
                                 got.now.seconds, got.now.minutes, got.now.hours, got.hit);
                    end
                end
            end
        end
        i_m_tready <= calm || ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_tod_item   phase_items[$];
        t_tod_time   walk;
        t_tod_time   target;
        t_tod_item   it;
        t_tod_result none;
        int          len;
        int          pick;
        int          ticks_seen;

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = CMD_TICK;
        i_m_tready = 1'b0;
        cycles       = 0;
        items_sent   = 0;
        loads_sent   = 0;
        results_seen = 0;
        alarm_hits   = 0;
        mism_count   = 0;
        phases_run   = 0;
        calm         = 1'b0;
        clock_now    = '0;
        alarm_time   = '0;
        none         = '0;

        // directed rows, alarm still at its reset value of all zeros
        add_row(tick_item(1'b0), 1'b1, mk_result(mk_time(0, 0, 0, 0), 1'b0));
        add_row(tick_item(1'b1), 1'b1, mk_result(mk_time(1, 0, 0, 0), 1'b0));
        add_row(load_item(mk_time(9, 7'h59, 7'h59, 8'h11), 1'b0), 1'b1,
                mk_result(mk_time(9, 7'h59, 7'h59, 8'h11), 1'b0));
        // 11:59:59.9 AM rolls to 00:00:00.0 PM
        add_row(tick_item(1'b1), 1'b1, mk_result(mk_time(0, 0, 0, 8'h80), 1'b0));
        add_row(load_item(mk_time(9, 7'h59, 7'h59, 8'h91), 1'b1), 1'b1,
                mk_result(mk_time(9, 7'h59, 7'h59, 8'h91), 1'b0));
        // PM rollover lands on the all-zero alarm
        add_row(tick_item(1'b1), 1'b1, mk_result(mk_time(0, 0, 0, 0), 1'b1));
        add_row(load_item(mk_time(15, 7'h7f, 7'h7f, 8'hff), 1'b0), 1'b1,
                mk_result(mk_time(15, 7'h7f, 7'h7f, 8'hff), 1'b0));
        add_row(tick_item(1'b1), 1'b1, mk_result(mk_time(0, 0, 0, 0), 1'b1));
        add_row(load_item(mk_time(3, 7'h65, 7'h70, 8'h69), 1'b1), 1'b1,
                mk_result(mk_time(3, 7'h65, 7'h70, 8'h69), 1'b0));
        add_row(tick_item(1'b0), 1'b1, mk_result(mk_time(3, 7'h65, 7'h70, 8'h69), 1'b0));
        add_row(tick_item(1'b1), 1'b0, none);
        add_row(load_item(mk_time(9, 7'h69, 7'h12, 8'h69), 1'b0), 1'b1,
                mk_result(mk_time(9, 7'h69, 7'h12, 8'h69), 1'b0));
        add_row(tick_item(1'b1), 1'b0, none);
        add_row(load_item(mk_time(9, 7'h59, 7'h59, 8'h69), 1'b1), 1'b0, none);
        add_row(tick_item(1'b1), 1'b0, none);
        add_row(load_item(mk_time(9, 7'h59, 7'h59, 8'h1a), 1'b0), 1'b0, none);
        add_row(tick_item(1'b1), 1'b0, none);
        add_row(load_item(mk_time(9, 7'h59, 7'h59, 8'h10), 1'b1), 1'b0, none);
        add_row(tick_item(1'b1), 1'b0, none);
        add_row(load_item(mk_time(12, 7'h09, 7'h7f, 8'h09), 1'b0), 1'b0, none);
        add_row(tick_item(1'b1), 1'b0, none);
        add_row(load_item(mk_time(9, 7'h5f, 7'h59, 8'h09), 1'b1), 1'b0, none);
        add_row(tick_item(1'b1), 1'b0, none);
        add_row(tick_item(1'b1), 1'b0, none);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);

        // random phases: alarm set while idle, then a burst of loads and ticks
        while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
            wait_idle();
            calm = (phases_run >= 3 && phases_run <= 5);

            phase_items.delete();
            len = $urandom_range(20, 60);
            phase_items.push_back(load_item(rand_time(), 1'($urandom)));
            if (phases_run == 1) phase_items[0] = load_item(mk_time(9, 7'h59, 7'h59, 8'h91), 1'b1);
            for (int n = 1; n < len; n++) begin
                if ($urandom_range(99) < 8)
                    phase_items.push_back(load_item(rand_time(), 1'($urandom)));
                else
                    phase_items.push_back(tick_item($urandom_range(99) < 90));
            end

            // aim the alarm at the time after one running tick of the burst
            target     = t_tod_time'($urandom);
            ticks_seen = 0;
            walk       = clock_now;
            pick       = $urandom_range(1, len - 1);
            foreach (phase_items[n]) begin
                it   = phase_items[n];
                walk = step_time(it, walk);
                if (it.cmd == CMD_TICK && it.running && (n <= pick || ticks_seen == 0)) begin
                    target = walk;
                    ticks_seen++;
                end
            end
            if (phases_run == 0) target = '1;
            else if (phases_run == 1) target = '0;
            else if ($urandom_range(99) < 20) target = t_tod_time'($urandom);
            set_alarm(target, 1'($urandom));

            foreach (phase_items[n]) send_item(phase_items[n], 1'b0, none);
            phases_run++;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d items (%0d loads) over %0d alarm settings; %0d results checked.",
                 items_sent, loads_sent, phases_run, results_seen);
        $display("Alarm hits seen: %0d, mismatches: %0d.", alarm_hits, mism_count);
        if (mism_count == 0 && pending_times.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
